// ===== sv/sphpf_pkg.sv =====
// Shared types, constants and helpers for the SPH pressure force accumulator.
package sphpf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 31;
    localparam int POS_W     = 32;
    localparam int SUM_W     = 48;
    localparam int COEF_W    = 47;
    localparam int ADDR_W    = 4;

    localparam logic [CFG_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [CFG_W-1:0] SCALE_RST  = 31'd250331;
    localparam logic [CFG_W-1:0] TARGET_RST = 31'd180224;
    localparam logic [CFG_W-1:0] PMUL_RST   = 31'd131072;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;
    localparam logic [1:0] REG_PMUL   = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] radius;
        logic [CFG_W-1:0] scale;
        logic [CFG_W-1:0] target;
        logic [CFG_W-1:0] pmul;
    } t_cfg;

    // classified neighbor item handed from front to back
    typedef struct packed {
        logic [2:0][CFG_W-1:0] dm;
        logic [2:0]            neg;
        logic [CFG_W-1:0]      nd;
        logic [CFG_W-1:0]      sd;
        logic                  skip;
        logic                  last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_ROOT, ST_CHK, ST_PM, ST_SLOPE, ST_P0, ST_P1,
        ST_QCHK, ST_QDIV, ST_DINIT, ST_DDIV, ST_DMUL, ST_ACC, ST_FIN
    } t_state;

    function automatic logic [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] s);
        logic [POS_W-1:0] r;
        if (s > $signed(48'sh0000_7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end else if (s < $signed(48'shFFFF_8000_0000)) begin
            r = 32'h8000_0000;
        end else begin
            r = s[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/sphpf_front.sv =====
// Front end: takes neighbor transfers, forms axis deltas and classifies far/self items.
module sphpf_front (
    input  logic                      i_rst_n,
    input  sphpf_pkg::t_cfg           i_cfg,
    input  logic                      i_valid,
    input  logic [253:0]              i_data,
    input  logic                      i_is_self,
    input  logic                      i_last,
    input  sphpf_pkg::t_fifo_st       i_fifo_st,
    output logic                      o_ready,
    output logic                      o_push,
    output sphpf_pkg::t_item          o_item
);

    logic signed [32:0] w_dl [3];
    logic [32:0]        w_dm [3];
    logic [2:0]         w_far;

    // per-axis signed difference, magnitude and range test
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dl[i] = $signed({i_data[32*i+31], i_data[32*i +: 32]})
                    - $signed({i_data[127+32*i+31], i_data[127+32*i +: 32]});
            w_dm[i] = w_dl[i][32] ? 33'(-w_dl[i]) : 33'(w_dl[i]);
            w_far[i] = (w_dm[i] >= {2'b0, i_cfg.radius});
            o_item.dm[i]  = w_dm[i][30:0];
            o_item.neg[i] = w_dl[i][32];
        end
        o_item.sd   = i_data[126:96];
        o_item.nd   = i_data[253:223];
        o_item.skip = i_is_self | (|w_far);
        o_item.last = i_last;
    end

    assign o_ready = i_rst_n & ~i_fifo_st.full;
    assign o_push  = i_valid & o_ready;

endmodule

// ===== sv/sphpf_fifo.sv =====
// Two-entry queue between the front end and the back end.
module sphpf_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sphpf_pkg::t_item      i_item,
    input  logic                  i_pop,
    output sphpf_pkg::t_item      o_item,
    output sphpf_pkg::t_fifo_st   o_st
);

    sphpf_pkg::t_item r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_item   = r_mem[r_rp];
    assign o_st.full  = (r_cnt == 2'd2);
    assign o_st.empty = (r_cnt == 2'd0);

endmodule

// ===== sv/sphpf_back.sv =====
// Back end: distance root, pressure coefficient, direction divides and force sums.
module sphpf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sphpf_pkg::t_cfg       i_cfg,
    input  sphpf_pkg::t_item      i_item,
    input  sphpf_pkg::t_fifo_st   i_fifo_st,
    input  logic                  i_m_tready,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    output logic [95:0]           o_m_tdata,
    output logic                  o_m_tuser
);

    sphpf_pkg::t_state r_state, n_state;
    sphpf_pkg::t_item  r_item;

    logic [63:0]  r_sum2;
    logic [63:0]  r_res;
    logic [63:0]  r_bit;
    logic [1:0]   r_k;
    logic [5:0]   r_cnt;
    logic         r_neg_sh;
    logic [32:0]  r_emag;
    logic [63:0]  r_pmprod;
    logic [45:0]  r_slope;
    logic [92:0]  r_prod;
    logic [30:0]  r_rem;
    logic [46:0]  r_low;
    logic [46:0]  r_coef;
    logic [16:0]  r_dir;
    logic [46:0]  r_add;
    logic signed [47:0] r_sum [3];
    logic         r_fault;
    logic         r_ovalid;
    logic [95:0]  r_odata;
    logic         r_ouser;

    logic         w_out_free;
    logic         w_load_out;
    logic [63:0]  w_rb;
    logic [31:0]  w_d;
    logic signed [33:0] w_esum;
    logic [30:0]  w_rd;
    logic [61:0]  w_sprod;
    logic [69:0]  w_p0;
    logic [68:0]  w_p1;
    logic [63:0]  w_dprod;
    logic [30:0]  w_dvsr;
    logic [31:0]  w_trial;
    logic         w_ge;
    logic [30:0]  w_rem_nx;
    logic signed [48:0] w_addend;
    logic signed [49:0] w_acc;
    logic signed [47:0] w_sat;
    logic [46:0]  w_smag;

    assign w_out_free = ~r_ovalid | i_m_tready;
    assign w_rb    = r_res + r_bit;
    assign w_d     = r_res[31:0];
    assign w_esum  = $signed({3'b0, r_item.nd}) + $signed({3'b0, r_item.sd})
                   - $signed({2'b0, i_cfg.target, 1'b0});
    assign w_rd    = i_cfg.radius - w_d[30:0];
    assign w_sprod = {31'd0, i_cfg.scale} * {31'd0, w_rd};
    assign w_smag  = r_pmprod[63:17];
    assign w_p0    = {46'd0, w_smag[23:0]} * {24'd0, r_slope};
    assign w_p1    = {46'd0, w_smag[46:24]} * {23'd0, r_slope};
    assign w_dprod = {17'd0, r_coef} * {47'd0, r_dir};

    // shared restoring divide step, one quotient bit per cycle
    assign w_dvsr   = (r_state == sphpf_pkg::ST_QDIV) ? r_item.nd : w_d[30:0];
    assign w_trial  = {r_rem, r_low[46]};
    assign w_ge     = (w_trial >= {1'b0, w_dvsr});
    assign w_rem_nx = w_ge ? 31'(w_trial - {1'b0, w_dvsr}) : w_trial[30:0];

    // signed accumulate with 48-bit saturation
    always_comb begin
        w_addend = (r_neg_sh ^ r_item.neg[r_k]) ? -$signed({2'b0, r_add})
                                                 : $signed({2'b0, r_add});
        w_acc = $signed({{2{r_sum[r_k][47]}}, r_sum[r_k]}) + $signed({w_addend[48], w_addend});
        if (w_acc > $signed(50'sh0_7FFF_FFFF_FFFF)) begin
            w_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (w_acc < $signed(50'sh3_8000_0000_0000)) begin
            w_sat = 48'sh8000_0000_0000;
        end else begin
            w_sat = w_acc[47:0];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sphpf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            sphpf_pkg::ST_IDLE: begin
                if (!i_fifo_st.empty) begin
                    o_pop   = 1'b1;
                    n_state = i_item.skip ? sphpf_pkg::ST_FIN : sphpf_pkg::ST_SQ;
                end
            end
            sphpf_pkg::ST_SQ: begin
                if (r_k == 2'd2) n_state = sphpf_pkg::ST_ROOT;
            end
            sphpf_pkg::ST_ROOT: begin
                if (r_bit[0]) n_state = sphpf_pkg::ST_CHK;
            end
            sphpf_pkg::ST_CHK: begin
                if ((w_d >= {1'b0, i_cfg.radius}) || (r_item.nd == '0) || (w_d == '0)) begin
                    n_state = sphpf_pkg::ST_FIN;
                end else begin
                    n_state = sphpf_pkg::ST_PM;
                end
            end
            sphpf_pkg::ST_PM:    n_state = sphpf_pkg::ST_SLOPE;
            sphpf_pkg::ST_SLOPE: n_state = sphpf_pkg::ST_P0;
            sphpf_pkg::ST_P0:    n_state = sphpf_pkg::ST_P1;
            sphpf_pkg::ST_P1:    n_state = sphpf_pkg::ST_QCHK;
            sphpf_pkg::ST_QCHK: begin
                if (r_prod[92:47] >= {15'd0, r_item.nd}) begin
                    n_state = sphpf_pkg::ST_DINIT;
                end else begin
                    n_state = sphpf_pkg::ST_QDIV;
                end
            end
            sphpf_pkg::ST_QDIV: begin
                if (r_cnt == '0) n_state = sphpf_pkg::ST_DINIT;
            end
            sphpf_pkg::ST_DINIT: n_state = sphpf_pkg::ST_DDIV;
            sphpf_pkg::ST_DDIV: begin
                if (r_cnt == '0) n_state = sphpf_pkg::ST_DMUL;
            end
            sphpf_pkg::ST_DMUL: n_state = sphpf_pkg::ST_ACC;
            sphpf_pkg::ST_ACC: begin
                n_state = (r_k == 2'd2) ? sphpf_pkg::ST_FIN : sphpf_pkg::ST_DINIT;
            end
            sphpf_pkg::ST_FIN: begin
                if (!r_item.last) begin
                    n_state = sphpf_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = sphpf_pkg::ST_IDLE;
                end
            end
            default: n_state = sphpf_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            sphpf_pkg::ST_IDLE: begin
                r_item <= i_item;
                r_sum2 <= '0;
                r_k    <= 2'd0;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end
            sphpf_pkg::ST_SQ: begin
                r_sum2 <= r_sum2 + {2'd0, {31'd0, r_item.dm[r_k]} * {31'd0, r_item.dm[r_k]}};
                r_k    <= r_k + 2'd1;
            end
            sphpf_pkg::ST_ROOT: begin
                if (r_sum2 >= w_rb) begin
                    r_sum2 <= r_sum2 - w_rb;
                    r_res  <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            sphpf_pkg::ST_CHK: begin
                r_neg_sh <= w_esum[33];
                r_emag   <= w_esum[33] ? 33'(-w_esum) : 33'(w_esum);
            end
            sphpf_pkg::ST_PM: begin
                r_pmprod <= {33'd0, i_cfg.pmul} * {31'd0, r_emag};
            end
            sphpf_pkg::ST_SLOPE: begin
                r_slope <= w_sprod[61:16];
            end
            sphpf_pkg::ST_P0: begin
                r_prod <= {23'd0, w_p0};
            end
            sphpf_pkg::ST_P1: begin
                r_prod <= r_prod + {w_p1, 24'd0};
            end
            sphpf_pkg::ST_QCHK: begin
                r_coef <= '1;
                r_rem  <= r_prod[77:47];
                r_low  <= r_prod[46:0];
                r_cnt  <= 6'd46;
                r_k    <= 2'd0;
            end
            sphpf_pkg::ST_QDIV: begin
                r_rem  <= w_rem_nx;
                r_low  <= {r_low[45:0], 1'b0};
                r_coef <= {r_coef[45:0], w_ge};
                r_cnt  <= r_cnt - 6'd1;
            end
            sphpf_pkg::ST_DINIT: begin
                r_rem <= {1'b0, r_item.dm[r_k][30:1]};
                r_low <= {r_item.dm[r_k][0], 46'd0};
                r_cnt <= 6'd16;
            end
            sphpf_pkg::ST_DDIV: begin
                r_rem <= w_rem_nx;
                r_low <= {r_low[45:0], 1'b0};
                r_dir <= {r_dir[15:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            sphpf_pkg::ST_DMUL: begin
                r_add <= w_dprod[62:16];
            end
            sphpf_pkg::ST_ACC: begin
                r_k <= r_k + 2'd1;
            end
            default: begin
            end
        endcase
    end

    // sums, fault flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_tready) r_ovalid <= 1'b0;
            if (r_state == sphpf_pkg::ST_CHK && w_d < {1'b0, i_cfg.radius}
                    && r_item.nd == '0) begin
                r_fault <= 1'b1;
            end
            if (r_state == sphpf_pkg::ST_ACC) begin
                r_sum[r_k] <= w_sat;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
                r_odata  <= {sphpf_pkg::sat32(r_sum[2]), sphpf_pkg::sat32(r_sum[1]),
                             sphpf_pkg::sat32(r_sum[0])};
                r_ouser  <= r_fault;
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                r_fault  <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule

// ===== sv/sph_pressure_force_accumulate_core.sv =====
// A self or far neighbor skips the arithmetic; an in-range neighbor runs a 32-step
// bitwise square root, a 47-step coefficient divide (skipped when the quotient
// saturates) and three 17-step direction divides on one shared restoring divider.
// The back end takes a new item only after it is through with the last one; a two-entry
// queue lets the input keep taking transfers meanwhile until it fills. Reset (synchronous,
// active low) clears the sums, the fault flag, the queue and the output, and restores the register defaults.
module sph_pressure_force_accumulate_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // neighbor stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: self_x, self_y, self_z, self_density, neighbor_x, neighbor_y,
    //        neighbor_z, neighbor_density, 2 zero pad bits
    input  logic [255:0] s_tdata,
    // tuser: neighbor_is_self
    input  logic         s_tuser,
    input  logic         s_tlast,
    // force stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: force_x, force_y, force_z
    output logic [95:0]  m_tdata,
    // tuser: zero_density_seen
    output logic         m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [sphpf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    sphpf_pkg::t_cfg      r_cfg;
    sphpf_pkg::t_item     w_front_item;
    sphpf_pkg::t_item     w_fifo_item;
    sphpf_pkg::t_fifo_st  w_fifo_st;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_cfg_wr;
    logic [1:0]           w_idx;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_idx    = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= sphpf_pkg::RADIUS_RST;
            r_cfg.scale  <= sphpf_pkg::SCALE_RST;
            r_cfg.target <= sphpf_pkg::TARGET_RST;
            r_cfg.pmul   <= sphpf_pkg::PMUL_RST;
        end else if (w_cfg_wr) begin
            case (w_idx)
                sphpf_pkg::REG_RADIUS: r_cfg.radius <= pwdata[30:0];
                sphpf_pkg::REG_SCALE:  r_cfg.scale  <= pwdata[30:0];
                sphpf_pkg::REG_TARGET: r_cfg.target <= pwdata[30:0];
                sphpf_pkg::REG_PMUL:   r_cfg.pmul   <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_idx)
            sphpf_pkg::REG_RADIUS: prdata = {1'b0, r_cfg.radius};
            sphpf_pkg::REG_SCALE:  prdata = {1'b0, r_cfg.scale};
            sphpf_pkg::REG_TARGET: prdata = {1'b0, r_cfg.target};
            sphpf_pkg::REG_PMUL:   prdata = {1'b0, r_cfg.pmul};
            default:               prdata = '0;
        endcase
    end

    sphpf_front u_front (
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_tvalid),
        .i_data    (s_tdata[253:0]),
        .i_is_self (s_tuser),
        .i_last    (s_tlast),
        .i_fifo_st (w_fifo_st),
        .o_ready   (s_tready),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    sphpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_fifo_item),
        .o_st    (w_fifo_st)
    );

    sphpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (w_fifo_item),
        .i_fifo_st  (w_fifo_st),
        .i_m_tready (m_tready),
        .o_pop      (w_pop),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // queue never reports full and empty at once
    a_fifo_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fifo_st.full && w_fifo_st.empty))
        else $error("queue status inconsistent");

    // back end only pops a queue that holds an item
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_st.empty)
        else $error("pop from empty queue");

    // front end never pushes into a full queue
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_st.full)
        else $error("push into full queue");

    // radius write lands in the register
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_idx == sphpf_pkg::REG_RADIUS) |=> r_cfg.radius == $past(pwdata[30:0]))
        else $error("radius write lost");

endmodule

// ===== bench/testbench.sv =====
// Testbench for the SPH pressure force accumulator: neighbor stream in, force stream out.
`timescale 1ns / 100ps

module testbench;

    localparam int        DRAIN_CYCLES = 600;
    localparam longint    CYCLE_LIMIT  = 3_000_000;
    localparam longint    SUM_HI       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint    SUM_LO       = -SUM_HI - 1;
    localparam longint unsigned COEF_MAX = 64'h0000_7FFF_FFFF_FFFF;

    // one neighbor transfer
    typedef struct {
        logic [31:0] sx, sy, sz, nx, ny, nz;
        logic [30:0] sd, nd;
        logic        is_self, last;
    } t_pair;

    // one emitted force
    typedef struct {
        logic [31:0] fx, fy, fz;
        logic        fault;
    } t_force;

    // predictor of the accumulated force plus the queue of pending forces
    class ForceScoreboard;
        longint unsigned radius, scale, target, pmul;
        longint          acc_x, acc_y, acc_z;
        bit              fault;
        t_force          pending[$];
        int              errors;
        int              forces_seen;

        function void clear_regs();
            radius = 64'(sphpf_pkg::RADIUS_RST);
            scale  = 64'(sphpf_pkg::SCALE_RST);
            target = 64'(sphpf_pkg::TARGET_RST);
            pmul   = 64'(sphpf_pkg::PMUL_RST);
            acc_x = 0; acc_y = 0; acc_z = 0; fault = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            longint unsigned v;
            v = 64'(val[30:0]);
            case (idx)
                sphpf_pkg::REG_RADIUS: radius = v;
                sphpf_pkg::REG_SCALE:  scale  = v;
                sphpf_pkg::REG_TARGET: target = v;
                sphpf_pkg::REG_PMUL:   pmul   = v;
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint sat_acc(longint s, longint v);
            longint t;
            t = s + v;
            if (t > SUM_HI) return SUM_HI;
            if (t < SUM_LO) return SUM_LO;
            return t;
        endfunction

        function logic [31:0] clip32(longint s);
            if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
            if (s < -64'sh8000_0000) return 32'h8000_0000;
            return s[31:0];
        endfunction

        // adds one neighbor's pressure force into the sums
        function void add_neighbor(t_pair p);
            longint          dl[3], esum, addv;
            longint unsigned dm[3], sq, d, emag, smag, slope, coef, dir;
            logic [127:0]    wide;
            bit              sneg;
            logic [31:0]     sp[3], np[3];
            sp[0] = p.sx; sp[1] = p.sy; sp[2] = p.sz;
            np[0] = p.nx; np[1] = p.ny; np[2] = p.nz;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                dl[i] = longint'($signed(sp[i])) - longint'($signed(np[i]));
                dm[i] = dl[i] < 0 ? -dl[i] : dl[i];
                if (dm[i] >= radius) return;
            end
            for (int i = 0; i < 3; i++) sq += dm[i] * dm[i];
            d = root(sq);
            if (d >= radius) return;
            if (p.nd == 0) begin
                fault = 1;
                return;
            end
            if (d == 0) return;
            esum = (longint'(p.nd) - longint'(target)) + (longint'(p.sd) - longint'(target));
            sneg = esum < 0;
            emag = sneg ? -esum : esum;
            smag = (pmul * emag) >> (sphpf_pkg::FRAC_BITS + 1);
            slope = (scale * (radius - d)) >> sphpf_pkg::FRAC_BITS;
            wide = (128'(smag) * 128'(slope)) / 128'(p.nd);
            coef = (wide > 128'(COEF_MAX)) ? COEF_MAX : wide[63:0];
            if (coef == 0) return;
            for (int i = 0; i < 3; i++) begin
                dir = (dm[i] << sphpf_pkg::FRAC_BITS) / d;
                wide = (128'(coef) * 128'(dir)) >> sphpf_pkg::FRAC_BITS;
                addv = (wide > 128'(COEF_MAX)) ? COEF_MAX : wide[63:0];
                if (sneg != (dl[i] < 0)) addv = -addv;
                if (i == 0) acc_x = sat_acc(acc_x, addv);
                else if (i == 1) acc_y = sat_acc(acc_y, addv);
                else acc_z = sat_acc(acc_z, addv);
            end
        endfunction

        function void note_input(t_pair p);
            t_force f;
            if (!p.is_self) add_neighbor(p);
            if (p.last) begin
                f.fx = clip32(acc_x); f.fy = clip32(acc_y); f.fz = clip32(acc_z);
                f.fault = fault;
                pending.push_back(f);
                acc_x = 0; acc_y = 0; acc_z = 0; fault = 0;
            end
        endfunction

        function void check_result(t_force got);
            t_force want;
            forces_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected force x=%h y=%h z=%h", got.fx, got.fy, got.fz);
                return;
            end
            want = pending.pop_front();
            if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
                got.fault !== want.fault) begin
                errors++;
                if (errors <= 10)
                    $display("force mismatch: want %h %h %h f%b got %h %h %h f%b",
                             want.fx, want.fy, want.fz, want.fault,
                             got.fx, got.fy, got.fz, got.fault);
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;   // sx, sy, sz, sd, nx, ny, nz, nd, pad (from bit 0 up)
    logic         s_tuser = 0;    // neighbor_is_self
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;        // force_x, force_y, force_z (from bit 0 up)
    logic         m_tuser;        // zero_density_seen
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [sphpf_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    ForceScoreboard sb = new();
    longint cycles = 0;
    bit     held = 0;

    sph_pressure_force_accumulate_core DUT (.*);

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_force f;
        if (i_rst_n && m_tvalid && m_tready) begin
            f.fx = m_tdata[31:0]; f.fy = m_tdata[63:32]; f.fz = m_tdata[95:64];
            f.fault = m_tuser;
            sb.check_result(f);
        end
    end

    // force receiver, with one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (!held && sb.forces_seen >= 20) begin
                held = 1;
                @(negedge i_clk);
                m_tready = 0;
                repeat (3000) @(negedge i_clk);
            end
            repeat (gap) begin
                @(negedge i_clk);
                m_tready = 0;
            end
            @(negedge i_clk);
            m_tready = 1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_pair(t_pair p);
        repeat ($urandom_range(0, 4)) begin
            @(negedge i_clk);
            s_tvalid = 0;
        end
        @(negedge i_clk);
        s_tdata = {2'b00, p.nd, p.nz, p.ny, p.nx, p.sd, p.sz, p.sy, p.sx};
        s_tuser = p.is_self;
        s_tlast = p.last;
        s_tvalid = 1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(p);
    endtask

    // waits until every force is out and the core has drained
    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 0;
        wait (sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // neighbor near the particle, or random noise now and then
    function automatic t_pair rand_pair(bit force_last);
        t_pair p;
        longint unsigned h;
        longint dv;
        logic [31:0] sp[3], np[3];
        h = sb.radius >> 1;
        for (int i = 0; i < 3; i++) begin
            sp[i] = $urandom;
            dv = longint'($urandom_range(0, 32'(2 * h))) - longint'(h);
            np[i] = sp[i] - dv[31:0];
        end
        p.sx = sp[0]; p.sy = sp[1]; p.sz = sp[2];
        p.nx = np[0]; p.ny = np[1]; p.nz = np[2];
        p.sd = 31'(sb.target + $urandom_range(0, 8 * 65536) - 4 * 65536);
        p.nd = 31'(sb.target + $urandom_range(0, 8 * 65536) - 4 * 65536);
        case ($urandom_range(0, 15))
            0, 1: begin
                p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
                p.nx = $urandom; p.ny = $urandom; p.nz = $urandom;
                p.sd = 31'($urandom); p.nd = 31'($urandom);
            end
            2: p.nd = 0;
            3: begin p.sd = 31'($urandom); p.nd = 31'($urandom); end
            default: ;
        endcase
        p.is_self = ($urandom_range(0, 11) == 0);
        p.last = force_last || ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic t_pair make_pair(logic [31:0] sx, logic [31:0] nx, logic [30:0] sd,
                                        logic [30:0] nd, bit is_self, bit last);
        t_pair p;
        p.sx = sx; p.sy = sx; p.sz = sx;
        p.nx = nx; p.ny = sx; p.nz = sx;
        p.sd = sd; p.nd = nd; p.is_self = is_self; p.last = last;
        return p;
    endfunction

    task automatic random_run(int n);
        for (int k = 0; k < n; k++) send_pair(rand_pair(k == n - 1));
        settle();
    endtask

    initial begin
        sb.clear_regs();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: special cases at default settings
        send_pair(make_pair(32'h0001_0000, 32'h0000_8000, 31'h0004_0000, 31'h0004_0000, 1, 1));
        send_pair(make_pair(32'h0001_0000, 32'h0000_C000, 31'h0001_0000, 31'h0006_0000, 0, 1));
        send_pair(make_pair(32'h0001_0000, 32'h0003_0000, 31'h0004_0000, 31'h0004_0000, 0, 1));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0));
        send_pair(make_pair(32'h1234_0000, 32'h1234_0000, 31'h0004_0000, 31'h0004_0000, 0, 1));
        send_pair(make_pair(32'h0000_4000, 32'h0000_0000, 31'h0004_0000, 31'h0000_0000, 0, 0));
        send_pair(make_pair(32'hFFFF_C000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0001, 0, 0));
        send_pair(make_pair(32'h8000_0000, 32'h8000_2000, 31'h0000_0000, 31'h7FFF_FFFF, 0, 1));
        for (int k = 0; k < 8; k++) send_pair(rand_pair(k == 7));
        settle();

        random_run(350);

        // extremes: widest radius and gain, zero target
        reg_write(sphpf_pkg::REG_RADIUS, 32'h7FFF_FFFF);
        reg_write(sphpf_pkg::REG_SCALE, 32'hFFFF_FFFF);
        reg_write(sphpf_pkg::REG_TARGET, 32'h0000_0000);
        reg_write(sphpf_pkg::REG_PMUL, 32'h7FFF_FFFF);
        random_run(250);

        // zero radius: every neighbor is far
        reg_write(sphpf_pkg::REG_RADIUS, 32'h0000_0000);
        reg_write(sphpf_pkg::REG_SCALE, 32'h0000_0000);
        random_run(40);

        // smallest radius: only coincident neighbors are in range
        reg_write(sphpf_pkg::REG_RADIUS, 32'h0000_0001);
        reg_write(sphpf_pkg::REG_TARGET, 32'h7FFF_FFFF);
        random_run(40);

        // random mid-range settings
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(sphpf_pkg::REG_RADIUS, $urandom_range(16'h4000, 32'h0080_0000));
            reg_write(sphpf_pkg::REG_SCALE, $urandom_range(0, 32'h0100_0000));
            reg_write(sphpf_pkg::REG_TARGET, $urandom_range(0, 32'h0010_0000));
            reg_write(sphpf_pkg::REG_PMUL, $urandom_range(0, 32'h0010_0000));
            random_run(120);
        end

        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
